### hw/rtl/kse_pkg.sv
// shared types and constants for the key sort engine
`timescale 1ns / 1ps

package kse_pkg;

   localparam int KSE_DEPTH = 64;
   localparam int KEY_W     = 19;
   localparam int TAG_W     = 6;
   localparam int REQ_DW    = 32;
   localparam int RSP_DW    = 32;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } rec_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

### hw/rtl/key_sort_engine_unit.sv
// top level of the key sort engine: insertion chain plus load / drain control
`timescale 1ns / 1ps
// latency: the first sorted result appears the cycle after the request marked last
// throughput: one request per cycle while loading; one result per cycle while draining,
//   as long as rsp_tready is high
// the rate is set by the chain of cells: every cell compares the incoming key at once
// reset: synchronous, clears all valid bits, the fill count and the overflow flag, and returns to loading

module key_sort_engine_unit #(
   parameter int DEPTH = kse_pkg::KSE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [kse_pkg::REQ_DW-1:0] req_tdata,   // key[18:0], tag[24:19], zero pad
   input  logic                       req_tlast,   // last request of the batch
   // result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [kse_pkg::RSP_DW-1:0] rsp_tdata,   // sorted_key[18:0], sorted_tag[24:19], zero pad
   output logic                       rsp_tlast,   // end_of_run
   output logic [0:0]                 rsp_tuser    // overflow
);
   import kse_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // control registers
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;

   // chain wiring
   rec_type       rec_w   [DEPTH];
   logic          valid_w [DEPTH];
   logic          take_w  [DEPTH];
   rec_type       new_rec;
   cell_ctrl_type ctrl;

   logic req_fire, rsp_fire, full;

   assign new_rec.key = req_tdata[KEY_W-1:0];
   assign new_rec.tag = req_tdata[KEY_W+TAG_W-1:KEY_W];

   assign req_tready = (state_ff == ST_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_DRAIN);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign full       = (count_ff == CNT_W'(DEPTH));

   // a request into a full chain is dropped and only flagged
   assign ctrl.insert = req_fire && !full;
   assign ctrl.shift  = rsp_fire;

   // row of cells; cell 0 holds the smallest key and feeds the result port
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      rec_type left_rec, right_rec;
      logic    left_valid, left_take, right_valid;

      if (i == 0) begin : g_head
         assign left_rec   = '0;
         assign left_valid = 1'b1;
         assign left_take  = 1'b0;
      end else begin : g_mid_l
         assign left_rec   = rec_w[i-1];
         assign left_valid = valid_w[i-1];
         assign left_take  = take_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_rec   = '0;
         assign right_valid = 1'b0;
      end else begin : g_mid_r
         assign right_rec   = rec_w[i+1];
         assign right_valid = valid_w[i+1];
      end

      kse_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_rec     (new_rec),
         .left_rec    (left_rec),
         .left_valid  (left_valid),
         .left_take   (left_take),
         .right_rec   (right_rec),
         .right_valid (right_valid),
         .rec         (rec_w[i]),
         .valid       (valid_w[i]),
         .take        (take_w[i])
      );
   end

   // load until the last request, then drain the chain from the head
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_LOAD: begin
            if (ctrl.insert) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (req_fire && full) begin
               dropped_in = 1'b1;
            end
            if (req_fire && req_tlast) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire) begin
               count_in = count_ff - CNT_W'(1);
               // batch done: start an empty one
               if (count_ff == CNT_W'(1)) begin
                  state_in   = ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // result comes straight from the head cell register
   assign rsp_tdata    = {{(RSP_DW-KEY_W-TAG_W){1'b0}}, rec_w[0].tag, rec_w[0].key};
   assign rsp_tlast    = (count_ff == CNT_W'(1));
   assign rsp_tuser[0] = dropped_ff;

endmodule

### hw/rtl/kse_cell.sv
// one slot of the insertion chain: holds a record, shifts right on insert, left on drain
`timescale 1ns / 1ps

module kse_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  kse_pkg::cell_ctrl_type ctrl,
   input  kse_pkg::rec_type       new_rec,
   input  kse_pkg::rec_type       left_rec,
   input  logic                   left_valid,
   input  logic                   left_take,
   input  kse_pkg::rec_type       right_rec,
   input  logic                   right_valid,
   output kse_pkg::rec_type       rec,
   output logic                   valid,
   output logic                   take
);
   import kse_pkg::*;

   rec_type rec_ff, rec_in;
   logic    valid_ff, valid_in;

   // empty slot counts as larger than any key; equal keys stay put
   assign take = !valid_ff || (rec_ff.key > new_rec.key);

   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      if (ctrl.insert) begin
         if (take) begin
            rec_in   = left_take ? left_rec : new_rec;
            valid_in = left_valid;
         end
      end else if (ctrl.shift) begin
         rec_in   = right_rec;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec   = rec_ff;
   assign valid = valid_ff;

endmodule
